@@ hdl/i2rd_pkg.sv @@
// shared types, constants and a function for the radix text converter
`timescale 1ns / 1ps
package i2rd_pkg;
   localparam int VALUE_WIDTH = 32;
   localparam int RADIX_WIDTH = 6;
   localparam int CHAR_WIDTH  = 7;
   localparam int DIGIT_WIDTH = 6;
   localparam int NUM_CELLS   = VALUE_WIDTH + 1;
   localparam int COUNT_WIDTH = $clog2(NUM_CELLS + 1);
   localparam int DIV_STEPS   = VALUE_WIDTH;
   localparam int STEP_WIDTH  = $clog2(DIV_STEPS + 1);
   localparam logic [RADIX_WIDTH-1:0] MIN_RADIX = 6'd2;
   localparam logic [RADIX_WIDTH-1:0] MAX_RADIX = 6'd36;
   localparam logic [CHAR_WIDTH-1:0]  MINUS_CHAR = 7'h2D;

   // character handed between neighbouring cells
   typedef struct packed {
      logic                  valid;
      logic [CHAR_WIDTH-1:0] char_code;
   } cell_data_type;

   // digit value to ascii
   function automatic logic [CHAR_WIDTH-1:0] digit_char(
      input logic [DIGIT_WIDTH-1:0] digit, input logic upper);
      logic [CHAR_WIDTH-1:0] base;
      begin
         base = upper ? 7'h37 : 7'h57;
         if (digit < 6'd10) digit_char = 7'h30 + CHAR_WIDTH'(digit);
         else               digit_char = base + CHAR_WIDTH'(digit);
      end
   endfunction
endpackage

@@ hdl/i2rd_cell.sv @@
// one cell of the character stack: loads from the left on push, from the right on pop
`timescale 1ns / 1ps
module i2rd_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic                    pop,
   input  i2rd_pkg::cell_data_type left_data,
   input  i2rd_pkg::cell_data_type right_data,
   output i2rd_pkg::cell_data_type data
);
   i2rd_pkg::cell_data_type data_ff, data_in;

   // push moves words away from the head, pop pulls them back toward it
   always_comb begin
      data_in = data_ff;
      if (push)     data_in = left_data;
      else if (pop) data_in = right_data;
   end

   always_ff @(posedge clock) begin
      if (reset) data_ff <= '0;
      else       data_ff <= data_in;
   end

   assign data = data_ff;
endmodule

@@ hdl/i2rd_divider.sv @@
// restoring divider, one quotient bit a cycle while busy
`timescale 1ns / 1ps
module i2rd_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [i2rd_pkg::VALUE_WIDTH-1:0]    dividend,
   input  logic [i2rd_pkg::RADIX_WIDTH-1:0]    divisor,
   output logic                                done,
   output logic [i2rd_pkg::VALUE_WIDTH-1:0]    quotient,
   output logic [i2rd_pkg::DIGIT_WIDTH-1:0]    remainder
);
   logic [i2rd_pkg::VALUE_WIDTH-1:0] quot_ff, quot_in;
   logic [i2rd_pkg::RADIX_WIDTH:0]   rem_ff, rem_in, trial;
   logic [i2rd_pkg::STEP_WIDTH-1:0]  step_ff, step_in;
   logic                             busy_ff, busy_in, done_ff, done_in;

   // load the dividend on start, else shift one dividend bit into the partial remainder
   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[i2rd_pkg::RADIX_WIDTH-1:0], quot_ff[i2rd_pkg::VALUE_WIDTH-1]};
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quot_in = {quot_ff[i2rd_pkg::VALUE_WIDTH-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            rem_in     = trial - {1'b0, divisor};
            quot_in[0] = 1'b1;
         end else begin
            rem_in = trial;
         end
         step_in = step_ff + 1'b1;
         if (step_ff == i2rd_pkg::STEP_WIDTH'(i2rd_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
   end

   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff[i2rd_pkg::DIGIT_WIDTH-1:0];
endmodule

@@ hdl/integer_to_radix_digits.sv @@
// digits are found least significant first
// a bad radix shows its single zero word in the cycle after it is taken
// output: one word a cycle from the head cell of the character stack while the receiver is ready
// one number at a time; the next number is taken after the last word
// reset: synchronous, clears the controller state, count and flags, the divider's busy and done flags and every cell
`timescale 1ns / 1ps
module integer_to_radix_digits (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // value
   input  logic [6:0]  req_tuser,   // radix, upper_case
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // character, zero pad
   output logic        rsp_tlast,   // last
   output logic        rsp_tuser    // bad_base
);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   localparam int N  = i2rd_pkg::NUM_CELLS;
   localparam int VW = i2rd_pkg::VALUE_WIDTH;

   logic [1:0]                         state_ff, state_in;
   logic [VW-1:0]                      mag_ff, mag_in;
   logic [i2rd_pkg::RADIX_WIDTH-1:0]   radix_ff, radix_in;
   logic                               upper_ff, upper_in, neg_ff, neg_in;
   logic                               bad_ff, bad_in;
   logic [i2rd_pkg::COUNT_WIDTH-1:0]   count_ff, count_in;
   logic                               div_start, div_done;
   logic [VW-1:0]                      quotient;
   logic [i2rd_pkg::DIGIT_WIDTH-1:0]   remainder;
   logic                               push, pop, accept_in, accept_out;
   i2rd_pkg::cell_data_type            head_data;
   i2rd_pkg::cell_data_type            cell_q [N];
   i2rd_pkg::cell_data_type            push_word;

   assign accept_in  = req_tvalid && req_tready;
   assign accept_out = rsp_tvalid && rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);

   i2rd_divider u_divider (
      .clock(clock), .reset(reset), .start(div_start), .dividend(mag_ff),
      .divisor(radix_ff), .done(div_done), .quotient(quotient), .remainder(remainder)
   );

   // controller: divide, push each digit, then the sign, then drain; a bad radix pushes one zero word and drains
   always_comb begin
      state_in  = state_ff;
      mag_in    = mag_ff;
      radix_in  = radix_ff;
      upper_in  = upper_ff;
      neg_in    = neg_ff;
      bad_in    = bad_ff;
      count_in  = count_ff;
      div_start = 1'b0;
      push      = 1'b0;
      push_word = '0;
      pop       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept_in) begin
               radix_in = req_tuser[5:0];
               upper_in = req_tuser[6];
               neg_in   = req_tdata[VW-1];
               mag_in   = req_tdata[VW-1] ? (VW'(0) - req_tdata) : req_tdata;
               bad_in   = (req_tuser[5:0] < i2rd_pkg::MIN_RADIX) ||
                          (req_tuser[5:0] > i2rd_pkg::MAX_RADIX);
               count_in = '0;
               if (bad_in) begin
                  // a bad radix never carries a sign
                  neg_in    = 1'b0;
                  push      = 1'b1;
                  push_word = '{valid: 1'b1, char_code: '0};
                  count_in  = i2rd_pkg::COUNT_WIDTH'(1);
                  state_in  = ST_OUT;
               end else begin
                  state_in  = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            div_start = 1'b1;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_done) begin
               push      = 1'b1;
               push_word = '{valid: 1'b1,
                             char_code: i2rd_pkg::digit_char(remainder, upper_ff)};
               count_in  = count_ff + 1'b1;
               mag_in    = quotient;
               if (quotient != '0) begin
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_OUT;
                  neg_in   = 1'b0;
                  if (neg_ff) neg_in = 1'b1;
               end
            end
         end
         ST_OUT: begin
            if (neg_ff) begin
               push      = 1'b1;
               push_word = '{valid: 1'b1, char_code: i2rd_pkg::MINUS_CHAR};
               count_in  = count_ff + 1'b1;
               neg_in    = 1'b0;
            end else if (accept_out) begin
               pop      = 1'b1;
               count_in = count_ff - 1'b1;
               if (count_ff == i2rd_pkg::COUNT_WIDTH'(1)) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         neg_ff   <= 1'b0;
         bad_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         neg_ff   <= neg_in;
         bad_ff   <= bad_in;
      end
      mag_ff   <= mag_in;
      radix_ff <= radix_in;
      upper_ff <= upper_in;
   end

   // row of cells; cell 0 is the head, the most recent word
   for (genvar i = 0; i < N; i++) begin : g_cell
      i2rd_cell u_cell (
         .clock(clock), .reset(reset), .push(push), .pop(pop),
         .left_data((i == 0) ? push_word : cell_q[(i == 0) ? 0 : i-1]),
         .right_data((i == N-1) ? '0 : cell_q[(i == N-1) ? i : i+1]),
         .data(cell_q[i])
      );
   end

   assign head_data  = cell_q[0];
   assign rsp_tvalid = (state_ff == ST_OUT) && !neg_ff && head_data.valid;
   assign rsp_tdata  = {1'b0, head_data.char_code};
   assign rsp_tlast  = (count_ff == i2rd_pkg::COUNT_WIDTH'(1));
   assign rsp_tuser  = bad_ff;
endmodule

@@ hdl/i2rd_checker.sv @@
// port-level checks for the radix text converter
`timescale 1ns / 1ps
module i2rd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tuser
);
   // no new number while words are being delivered
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("input taken during output");
   // a bad radix word is a single zero word
   a_bad_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tlast && rsp_tdata == 8'd0))
      else $error("bad radix word malformed");
   // padding bit stays clear
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[7]) else $error("pad bit set");
   // stalled word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled word changed");
endmodule

bind integer_to_radix_digits i2rd_checker u_i2rd_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser)
);

@@ dv/tb_top.sv @@
// self-checking testbench for the radix text converter
`timescale 1ns / 1ps
class digit_scoreboard;
   typedef struct {
      logic [6:0] character;
      logic       last;
      logic       bad_base;
   } text_char_type;

   text_char_type pending_chars[$];
   int            fail_count;

   // note an accepted number and queue its expected text
   function void note_number(logic [31:0] value, logic [5:0] radix, logic upper);
      logic [31:0]   mag;
      logic [6:0]    rev[$];
      logic [6:0]    digit;
      text_char_type c;
      int            n;
      if (radix < i2rd_pkg::MIN_RADIX || radix > i2rd_pkg::MAX_RADIX) begin
         c.character = '0;
         c.last = 1'b1;
         c.bad_base = 1'b1;
         pending_chars.push_back(c);
         return;
      end
      mag = value[31] ? (32'd0 - value) : value;
      do begin
         digit = 7'(mag % radix);
         if (digit < 7'd10) rev.push_back(7'h30 + digit);
         else               rev.push_back((upper ? 7'h37 : 7'h57) + digit);
         mag = mag / radix;
      end while (mag != 0);
      if (value[31]) rev.push_back(i2rd_pkg::MINUS_CHAR);
      n = rev.size();
      for (int k = 0; k < n; k++) begin
         c.character = rev[n - 1 - k];
         c.last = (k == n - 1);
         c.bad_base = 1'b0;
         pending_chars.push_back(c);
      end
   endfunction

   // compare one received word with the oldest expected character
   function void check_char(logic [7:0] data, logic last, logic bad);
      text_char_type c;
      if (pending_chars.size() == 0) begin
         $error("unexpected word: data %h last %b bad_base %b", data, last, bad);
         fail_count++;
         return;
      end
      c = pending_chars.pop_front();
      if (data !== {1'b0, c.character}) begin
         $error("character: expected %h actual %h", c.character, data);
         fail_count++;
      end
      if (last !== c.last) begin
         $error("last: expected %b actual %b", c.last, last);
         fail_count++;
      end
      if (bad !== c.bad_base) begin
         $error("bad_base: expected %b actual %b", c.bad_base, bad);
         fail_count++;
      end
   endfunction
endclass

module tb_top;
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // value
   logic [6:0]  req_tuser = '0;   // radix, upper_case
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;       // character, zero pad
   logic        rsp_tlast;       // last
   logic        rsp_tuser;       // bad_base

   int send_idle_pct = 34;
   int recv_idle_pct = 46;
   bit sending_done  = 1'b0;
   digit_scoreboard text_board = new();

   integer_to_radix_digits DUT (.*);

   always #5 clock = ~clock;

   // send one number, idling at random before it; valid stays up for back to back numbers
   task automatic send_number(logic [31:0] value, logic [5:0] radix, logic upper);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= {upper, radix};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      text_board.note_number(value, radix, upper);
      @(negedge clock);
   endtask

   // random number with a bias towards valid radices and edge values
   task automatic send_random();
      logic [31:0] value;
      logic [5:0]  radix;
      case ($urandom_range(5))
         0: value = $urandom_range(40);
         1: value = -$urandom_range(40);
         2: value = {1'($urandom_range(1)), 31'h0} | $urandom_range(3);
         default: value = $urandom;
      endcase
      if ($urandom_range(9) == 0) radix = 6'($urandom_range(63));
      else                         radix = 6'($urandom_range(36, 2));
      send_number(value, radix, 1'($urandom_range(1)));
   endtask

   // receiver: random stalls, check at the rising edge
   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready)
         text_board.check_char(rsp_tdata, rsp_tlast, rsp_tuser);

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // directed: extremes, both cases, bad radices, the most negative value
      send_number(32'd0, 6'd10, 1'b0);
      send_number(32'h7FFF_FFFF, 6'd2, 1'b0);
      send_number(32'h8000_0000, 6'd2, 1'b0);
      send_number(32'h8000_0000, 6'd10, 1'b1);
      send_number(32'hFFFF_FFFF, 6'd36, 1'b1);
      send_number(32'h7FFF_FFFF, 6'd36, 1'b0);
      send_number(32'hDEAD_BEEF, 6'd16, 1'b1);
      send_number(32'hDEAD_BEEF, 6'd16, 1'b0);
      send_number(32'd35, 6'd36, 1'b1);
      send_number(32'd35, 6'd36, 1'b0);
      send_number(32'd12345, 6'd0, 1'b0);
      send_number(32'd12345, 6'd1, 1'b1);
      send_number(32'd12345, 6'd37, 1'b0);
      send_number(32'h5555_5555, 6'd63, 1'b1);
      send_number(32'hAAAA_AAAA, 6'd3, 1'b0);
      send_number(32'h8000_0000, 6'd36, 1'b0);
      send_number(-32'sd1, 6'd2, 1'b1);
      // random in three idling phases
      for (int i = 0; i < 135; i++) send_random();
      send_idle_pct = 46;
      recv_idle_pct = 34;
      for (int i = 0; i < 135; i++) send_random();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int i = 0; i < 135; i++) send_random();
      req_tvalid <= 1'b0;
      sending_done = 1'b1;
   end

   // wait for the last text to drain, then report
   initial begin
      wait (sending_done);
      while (text_board.pending_chars.size() != 0) @(posedge clock);
      repeat (1200) @(posedge clock);
      if (text_board.fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #20ms;
      $display("status: fail");
      $finish;
   end
endmodule
